// File: rtl/fat_pkg.sv
// ============================================================================
// fat_pkg: shared types and constants of the block allocation table manager
// Field widths, operation and status codes, link tags and sequencer states.
// ============================================================================
`default_nettype none

package fat_pkg;

    // Fixed field widths.
    localparam int MODE_W    = 2;
    localparam int LEN_W     = 13;
    localparam int BLK_W     = 6;
    localparam int STAT_W    = 2;
    localparam int TAG_W     = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    // Defaults for the top level parameters.
    localparam int NUM_BLOCKS_DEF  = 64;
    localparam int BLOCK_BYTES_DEF = 64;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WALK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_SPACE   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_START_FREE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_TOO_LONG   = 2'd3;

    // Link tags kept in the table.
    localparam logic [TAG_W-1:0] TAG_FREE = 2'd0;
    localparam logic [TAG_W-1:0] TAG_LINK = 2'd1;
    localparam logic [TAG_W-1:0] TAG_END  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEED,
        ST_SCAN1,
        ST_SCAN2,
        ST_CH_RD,
        ST_CH_TAG,
        ST_EMIT
    } fat_state_t;

endpackage

`default_nettype wire

// File: rtl/fat_ram.sv
// ============================================================================
// fat_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
`default_nettype none

module fat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/fat_chain_block_manager.sv
// ============================================================================
// fat_chain_block_manager: chained block allocation table manager
// Allocates, walks and frees chains of blocks kept as per-block links.
// ============================================================================
// One command is taken at a time and the block stays busy until its last
// result transfer completes. Allocate first sizes the request as
// ceil(byte_length / BLOCK_BYTES) blocks, at least one, with one shared add
// and compare, then counts free blocks and then links them, one table entry
// per cycle while no result waits on the output. Walk and free traverse the
// chain twice (once to check that it ends, once to emit), visiting each
// block through a read state and a tag state because the link table is read
// through its registered RAM port. The free-block flags reset at once, so no
// clearing pass is needed.
`default_nettype none

module fat_chain_block_manager
    import fat_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // byte_length[12:0], start_block[18:13]
    input  wire logic [MODE_W-1:0]    s_tuser,  // mode[1:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,  // block_index[5:0]
    output logic      [STAT_W-1:0]    m_tuser,  // status[1:0]
    output logic                      m_tlast
);

    localparam int AW       = $clog2(NUM_BLOCKS);
    localparam int CNT_W    = $clog2(NUM_BLOCKS + 1);
    localparam int ACC_BITS = $clog2(NUM_BLOCKS * BLOCK_BYTES + 1);
    localparam int CMP_W    = (ACC_BITS > LEN_W) ? ACC_BITS : LEN_W;
    localparam logic [CNT_W-1:0] NB_CNT = CNT_W'(NUM_BLOCKS);
    localparam logic [BLK_W:0]   NB_EXT = (BLK_W + 1)'(NUM_BLOCKS);
    localparam logic [CMP_W-1:0] BB_ACC = CMP_W'(BLOCK_BYTES);

    fat_state_t state_reg, state_next;
    fat_state_t ret_reg, ret_next;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BLK_W-1:0]  start_reg, start_next;
    logic [CMP_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  need_reg, need_next;
    logic [CNT_W-1:0]  found_reg, found_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BLK_W-1:0]  cur_reg, cur_next;
    logic [BLK_W-1:0]  prev_reg, prev_next;
    logic              have_prev_reg, have_prev_next;
    logic              pass2_reg, pass2_next;
    logic              vld_rd_reg, vld_rd_next;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [BLK_W-1:0]  out_block_reg, out_block_next;
    logic              out_last_reg, out_last_next;

    // A block is in use exactly while its flag is set.
    logic [NUM_BLOCKS-1:0] valid_reg;
    logic                  set_en, clr_en;
    logic [AW-1:0]         set_idx, clr_idx;

    logic              tag_we, link_we, rd_en;
    logic [AW-1:0]     tag_waddr, link_waddr;
    logic [TAG_W-1:0]  tag_wdata, tag_rdata;
    logic [BLK_W-1:0]  link_wdata, link_rdata;

    logic              scan_free;
    logic              alloc_last;
    logic [BLK_W-1:0]  scan_blk;

    fat_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_BLOCKS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (rd_en),
        .raddr (cur_reg[AW-1:0]),
        .rdata (tag_rdata)
    );

    fat_ram #(
        .WIDTH (BLK_W),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (rd_en),
        .raddr (cur_reg[AW-1:0]),
        .rdata (link_rdata)
    );

    assign scan_free  = !valid_reg[idx_reg[AW-1:0]];
    assign alloc_last = (CNT_W'(found_reg + 1'b1) == need_reg);
    assign scan_blk   = BLK_W'(idx_reg);

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        mode_next       = mode_reg;
        len_next        = len_reg;
        start_next      = start_reg;
        acc_next        = acc_reg;
        need_next       = need_reg;
        found_next      = found_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        pass2_next      = pass2_reg;
        vld_rd_next     = vld_rd_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_block_next  = out_block_reg;
        out_last_next   = out_last_reg;
        set_en          = 1'b0;
        set_idx         = idx_reg[AW-1:0];
        clr_en          = 1'b0;
        clr_idx         = prev_reg[AW-1:0];
        tag_we          = 1'b0;
        tag_waddr       = idx_reg[AW-1:0];
        tag_wdata       = TAG_END;
        link_we         = 1'b0;
        link_waddr      = prev_reg[AW-1:0];
        link_wdata      = scan_blk;
        rd_en           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next      = s_tuser;
                    len_next       = s_tdata[LEN_W-1:0];
                    start_next     = s_tdata[LEN_W+BLK_W-1:LEN_W];
                    cur_next       = s_tdata[LEN_W+BLK_W-1:LEN_W];
                    acc_next       = BB_ACC;
                    need_next      = CNT_W'(1);
                    count_next     = '0;
                    have_prev_next = 1'b0;
                    pass2_next     = 1'b0;
                    if (s_tuser == MODE_ALLOC)
                    begin
                        state_next = ST_NEED;
                    end
                    else if (s_tuser inside {MODE_WALK, MODE_FREE})
                    begin
                        state_next = ST_CH_RD;
                    end
                end
            end

            // Smallest block count whose capacity covers the length.
            ST_NEED:
            begin
                if (acc_reg >= CMP_W'(len_reg))
                begin
                    idx_next   = '0;
                    found_next = '0;
                    state_next = ST_SCAN1;
                end
                else if (need_reg == NB_CNT)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_NO_SPACE;
                    out_block_next  = '0;
                    out_last_next   = 1'b1;
                    ret_next        = ST_IDLE;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    need_next = CNT_W'(need_reg + 1'b1);
                    acc_next  = CMP_W'(acc_reg + BB_ACC);
                end
            end

            // First pass only counts free blocks so that a failed request
            // leaves the table untouched.
            ST_SCAN1:
            begin
                if (idx_reg == NB_CNT)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_NO_SPACE;
                    out_block_next  = '0;
                    out_last_next   = 1'b1;
                    ret_next        = ST_IDLE;
                    state_next      = ST_EMIT;
                end
                else if (scan_free && alloc_last)
                begin
                    idx_next       = '0;
                    found_next     = '0;
                    have_prev_next = 1'b0;
                    state_next     = ST_SCAN2;
                end
                else
                begin
                    if (scan_free)
                    begin
                        found_next = CNT_W'(found_reg + 1'b1);
                    end
                    idx_next = CNT_W'(idx_reg + 1'b1);
                end
            end

            ST_SCAN2:
            begin
                idx_next = CNT_W'(idx_reg + 1'b1);
                if (scan_free)
                begin
                    tag_we          = 1'b1;
                    tag_wdata       = alloc_last ? TAG_END : TAG_LINK;
                    link_we         = have_prev_reg;
                    set_en          = 1'b1;
                    prev_next       = scan_blk;
                    have_prev_next  = 1'b1;
                    found_next      = CNT_W'(found_reg + 1'b1);
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_block_next  = scan_blk;
                    out_last_next   = alloc_last;
                    ret_next        = alloc_last ? ST_IDLE : ST_SCAN2;
                    state_next      = ST_EMIT;
                end
            end

            ST_CH_RD:
            begin
                rd_en       = 1'b1;
                vld_rd_next = ({1'b0, cur_reg} < NB_EXT) && valid_reg[cur_reg[AW-1:0]];
                state_next  = ST_CH_TAG;
            end

            // The candidate block's tag and link are on the RAM outputs.
            // A pending previous block is resolved first: it is the last
            // one when the candidate turns out to be free.
            ST_CH_TAG:
            begin
                if (!vld_rd_reg)
                begin
                    if (!have_prev_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_START_FREE;
                        out_block_next  = start_reg;
                        out_last_next   = 1'b1;
                        ret_next        = ST_IDLE;
                        state_next      = ST_EMIT;
                    end
                    else if (!pass2_reg)
                    begin
                        cur_next       = start_reg;
                        count_next     = '0;
                        have_prev_next = 1'b0;
                        pass2_next     = 1'b1;
                        state_next     = ST_CH_RD;
                    end
                    else
                    begin
                        clr_en          = (mode_reg == MODE_FREE);
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_OK;
                        out_block_next  = prev_reg;
                        out_last_next   = 1'b1;
                        ret_next        = ST_IDLE;
                        state_next      = ST_EMIT;
                    end
                end
                else if (have_prev_reg)
                begin
                    have_prev_next = 1'b0;
                    if (pass2_reg)
                    begin
                        clr_en          = (mode_reg == MODE_FREE);
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_OK;
                        out_block_next  = prev_reg;
                        out_last_next   = 1'b0;
                        ret_next        = ST_CH_TAG;
                        state_next      = ST_EMIT;
                    end
                end
                else if (count_reg == NB_CNT)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_TOO_LONG;
                    out_block_next  = start_reg;
                    out_last_next   = 1'b1;
                    ret_next        = ST_IDLE;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    count_next = CNT_W'(count_reg + 1'b1);
                    if (tag_rdata != TAG_LINK || {1'b0, link_rdata} >= NB_EXT)
                    begin
                        if (!pass2_reg)
                        begin
                            cur_next       = start_reg;
                            count_next     = '0;
                            have_prev_next = 1'b0;
                            pass2_next     = 1'b1;
                            state_next     = ST_CH_RD;
                        end
                        else
                        begin
                            clr_en          = (mode_reg == MODE_FREE);
                            clr_idx         = cur_reg[AW-1:0];
                            out_valid_next  = 1'b1;
                            out_status_next = STAT_OK;
                            out_block_next  = cur_reg;
                            out_last_next   = 1'b1;
                            ret_next        = ST_IDLE;
                            state_next      = ST_EMIT;
                        end
                    end
                    else
                    begin
                        prev_next      = cur_reg;
                        have_prev_next = 1'b1;
                        cur_next       = link_rdata;
                        state_next     = ST_CH_RD;
                    end
                end
            end

            ST_EMIT:
            begin
                if (m_tready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = ret_reg;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
            if (set_en)
            begin
                valid_reg[set_idx] <= 1'b1;
            end
            if (clr_en)
            begin
                valid_reg[clr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        len_reg        <= len_next;
        start_reg      <= start_next;
        acc_reg        <= acc_next;
        need_reg       <= need_next;
        found_reg      <= found_next;
        idx_reg        <= idx_next;
        count_reg      <= count_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        have_prev_reg  <= have_prev_next;
        pass2_reg      <= pass2_next;
        vld_rd_reg     <= vld_rd_next;
        out_status_reg <= out_status_next;
        out_block_reg  <= out_block_next;
        out_last_reg   <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_block_reg);
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // A new command is never taken while a result is still on offer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("command accepted while a result is pending");

    // Every error status is the single and final result of its command.
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != STAT_OK) |-> m_tlast)
        else $error("error status without last flag");

    // After a command transfer other than the unused mode, the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser != MODE_UNUSED) |=> !s_tready)
        else $error("ready right after a command transfer");

endmodule

`default_nettype wire

// File: sim/fat_chain_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// fat_chain_checker: result predictor and scoreboard for the chain manager
// Watches both stream channels, keeps its own copy of the block link table,
// predicts the results of every accepted command and compares each result
// transfer field by field against the oldest pending prediction.
// ============================================================================

module fat_chain_checker
    import fat_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [MODE_W-1:0]    s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [STAT_W-1:0]    m_tuser,
    input  logic                 m_tlast,
    output int                   fail_count,
    output int                   pending
);

    localparam int TABLE_SLOTS = 1 << BLK_W;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BLK_W-1:0]  blk;
        logic              last;
    } chain_result_t;

    chain_result_t    expected_q [$];
    chain_result_t    got_res;
    chain_result_t    want_res;
    logic [TAG_W-1:0] tag_tbl    [TABLE_SLOTS];
    logic [BLK_W-1:0] link_tbl   [TABLE_SLOTS];

    initial
    begin
        fail_count = 0;
        pending    = 0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            tag_tbl[i]  = TAG_FREE;
            link_tbl[i] = '0;
        end
    end

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got_v, want_v);
        fail_count++;
    endtask

    function automatic void push_result(input logic [STAT_W-1:0] st, input int blk,
                                        input logic last);
        chain_result_t r;
        r.status   = st;
        r.blk      = BLK_W'(blk);
        r.last     = last;
        expected_q = {expected_q, r};
    endfunction

    // First-fit allocation in ascending block order; nothing changes when
    // there are not enough free blocks.
    task automatic predict_alloc(input logic [LEN_W-1:0] len);
        int need;
        int found;
        int chosen [TABLE_SLOTS];
        need  = (int'(len) + BLOCK_BYTES - 1) / BLOCK_BYTES;
        found = 0;
        if (need == 0)
            need = 1;
        if (need <= NUM_BLOCKS)
        begin
            for (int i = 0; i < NUM_BLOCKS && found < need; i++)
            begin
                if (tag_tbl[i] == TAG_FREE)
                begin
                    chosen[found] = i;
                    found++;
                end
            end
        end
        if (found < need)
            push_result(STAT_NO_SPACE, 0, 1'b1);
        else
        begin
            for (int i = 0; i < found; i++)
            begin
                if (i + 1 < found)
                begin
                    tag_tbl[chosen[i]]  = TAG_LINK;
                    link_tbl[chosen[i]] = BLK_W'(chosen[i + 1]);
                end
                else
                    tag_tbl[chosen[i]] = TAG_END;
                push_result(STAT_OK, chosen[i], i + 1 == found);
            end
        end
    endtask

    // Walk or free. A chain stops at any entry that is not a link, and at a
    // link that points to a free or out-of-table block.
    task automatic predict_chain(input logic [BLK_W-1:0] start, input logic release_blk);
        int path [TABLE_SLOTS];
        int count;
        int cur;
        int nx;
        logic ended;
        cur   = int'(start);
        count = 0;
        ended = 1'b0;
        if (cur >= NUM_BLOCKS || tag_tbl[cur] == TAG_FREE)
            push_result(STAT_START_FREE, cur, 1'b1);
        else
        begin
            while (count < NUM_BLOCKS && !ended)
            begin
                path[count] = cur;
                count++;
                if (tag_tbl[cur] != TAG_LINK)
                    ended = 1'b1;
                else
                begin
                    nx = int'(link_tbl[cur]);
                    if (nx >= NUM_BLOCKS || tag_tbl[nx] == TAG_FREE)
                        ended = 1'b1;
                    else
                        cur = nx;
                end
            end
            if (!ended)
                push_result(STAT_TOO_LONG, int'(start), 1'b1);
            else
            begin
                for (int i = 0; i < count; i++)
                begin
                    if (release_blk)
                        tag_tbl[path[i]] = TAG_FREE;
                    push_result(STAT_OK, path[i], i + 1 == count);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
                tag_tbl[i] = TAG_FREE;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            // Results first: a result can never belong to a command accepted
            // at the same edge.
            if (m_tvalid && m_tready)
            begin
                got_res.status = m_tuser;
                got_res.blk    = m_tdata[BLK_W-1:0];
                got_res.last   = m_tlast;
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result transfer, block_index",
                                    int'(got_res.blk), -1);
                else
                begin
                    want_res = expected_q.pop_front();
                    if (got_res.status != want_res.status)
                        report_mismatch("status", int'(got_res.status),
                                        int'(want_res.status));
                    if (got_res.blk != want_res.blk)
                        report_mismatch("block_index", int'(got_res.blk),
                                        int'(want_res.blk));
                    if (got_res.last != want_res.last)
                        report_mismatch("last_of_run", int'(got_res.last),
                                        int'(want_res.last));
                end
            end
            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    MODE_ALLOC: predict_alloc(s_tdata[LEN_W-1:0]);
                    MODE_WALK:  predict_chain(s_tdata[LEN_W +: BLK_W], 1'b0);
                    MODE_FREE:  predict_chain(s_tdata[LEN_W +: BLK_W], 1'b1);
                    default:    ; // the unused mode leaves the table alone
                endcase
            end
            pending <= expected_q.size();
        end
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench for the chained block allocation table manager
// Drives allocate, walk and free commands with random gaps and back-pressure,
// and lets the checker predict and compare every result transfer.
// ============================================================================

module tb_top
    import fat_pkg::*;
();

    localparam int TABLE_SLOTS    = 1 << BLK_W;
    localparam int RANDOM_ITEMS   = 500;
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [MODE_W-1:0]      s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STAT_W-1:0]      m_tuser;
    logic                   m_tlast;

    int                     fail_count;
    int                     pending;
    int                     stall_left   = 0;
    int                     hold_left    = 0;
    int                     idle_cycles  = 0;
    logic                   hold_go      = 1'b0;
    logic                   hold_done    = 1'b0;
    logic                   quiet        = 1'b0;
    logic [MODE_W-1:0]      active_mode  = '0;
    logic [TABLE_SLOTS-1:0] live_blocks  = '0;

    always #2 clk = ~clk;

    fat_chain_block_manager i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    fat_chain_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result receiver: one long hold-off when asked, otherwise random stall
    // bursts until the quiet phase at the end.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 15);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Blocks seen in use steer walk and free toward real chains. Results
    // belong to the last accepted command since only one runs at a time.
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            active_mode <= s_tuser;
        if (m_tvalid && m_tready && m_tuser == STAT_OK)
            live_blocks[m_tdata[BLK_W-1:0]] <= (active_mode != MODE_FREE);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_cmd(input logic [MODE_W-1:0] op, input logic [LEN_W-1:0] len,
                            input logic [BLK_W-1:0] blk);
        int gap;
        logic [S_TDATA_W-1:0] word;
        gap  = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
        word = '0;
        word[LEN_W-1:0]      = len;
        word[LEN_W +: BLK_W] = blk;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int iter;
        int issued;
        int sel;
        int base;
        logic [MODE_W-1:0] op;
        logic [LEN_W-1:0]  len;
        logic [BLK_W-1:0]  blk;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on an empty table, so every block index is known.
        send_cmd(MODE_WALK,   13'h1FFF, 6'd0);    // start block free
        send_cmd(MODE_FREE,   13'h1FFF, 6'd5);    // start block free
        send_cmd(MODE_ALLOC,  13'd0,    6'h3F);   // zero length still takes a block
        send_cmd(MODE_ALLOC,  13'd1,    6'h3F);
        send_cmd(MODE_ALLOC,  13'd64,   6'h3F);
        send_cmd(MODE_ALLOC,  13'd65,   6'h3F);   // two blocks
        send_cmd(MODE_ALLOC,  13'd200,  6'h3F);   // blocks 5 to 8
        send_cmd(MODE_WALK,   13'd0,    6'd5);
        send_cmd(MODE_FREE,   13'd0,    6'd7);    // cut the chain in the middle
        send_cmd(MODE_WALK,   13'd0,    6'd5);    // link to a free block ends it
        send_cmd(MODE_ALLOC,  13'd4096, 6'd0);    // no space
        send_cmd(MODE_ALLOC,  13'h1FFF, 6'd0);    // more blocks than the table
        send_cmd(MODE_UNUSED, 13'h1FFF, 6'h3F);
        send_cmd(MODE_WALK,   13'd0,    6'd63);
        send_cmd(MODE_FREE,   13'd0,    6'd0);
        send_cmd(MODE_FREE,   13'd0,    6'd1);
        send_cmd(MODE_FREE,   13'd0,    6'd2);
        send_cmd(MODE_FREE,   13'd0,    6'd3);
        send_cmd(MODE_FREE,   13'd0,    6'd5);
        send_cmd(MODE_ALLOC,  13'd4096, 6'd0);    // whole table in one chain
        send_cmd(MODE_WALK,   13'd0,    6'd0);
        send_cmd(MODE_FREE,   13'd0,    6'd0);
        send_cmd(MODE_FREE,   13'd0,    6'd0);
        send_cmd(MODE_ALLOC,  13'd4033, 6'd0);
        send_cmd(MODE_FREE,   13'd0,    6'd63);   // release only the end block
        send_cmd(MODE_WALK,   13'd0,    6'd0);
        send_cmd(MODE_FREE,   13'd0,    6'd0);

        iter   = 0;
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            if (iter == 150)
                hold_go <= 1'b1;
            if (iter == 300)
            begin
                // Let the block drain completely before going on.
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            if (iter == RANDOM_ITEMS - 70)
                quiet <= 1'b1;

            sel = $urandom_range(0, 99);
            len = LEN_W'($urandom);
            blk = BLK_W'($urandom);
            if (sel < 4)
                op = MODE_UNUSED;
            else if (sel < 46)
            begin
                op  = MODE_ALLOC;
                sel = $urandom_range(0, 19);
                if (sel != 0)
                    len = (sel < 3) ? LEN_W'($urandom_range(1024, 4096))
                                    : LEN_W'($urandom_range(0, 400));
            end
            else
            begin
                op = (sel < 70) ? MODE_WALK : MODE_FREE;
                if ($urandom_range(0, 9) != 0)
                begin
                    base = $urandom_range(0, TABLE_SLOTS - 1);
                    for (int k = TABLE_SLOTS - 1; k >= 0; k--)
                        if (live_blocks[(base + k) % TABLE_SLOTS])
                            blk = BLK_W'((base + k) % TABLE_SLOTS);
                end
            end
            send_cmd(op, len, blk);
            if (op != MODE_UNUSED)
                issued++;
            iter++;
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
